// ===== rtl/positional_list_engine_unit_defines.svh =====
// Assertion macros used by the checker file of the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define PLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("positional list engine: implication failed");

// Next-cycle implication, held off while reset is asserted.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("positional list engine: next-cycle implication failed");

`endif

// ===== rtl/ple_pkg.sv =====
// Shared constants, codes and types of the positional list engine.
package ple_pkg;

	// Storage and field sizes.
	localparam int CAPACITY   = 64;
	localparam int ITEM_W     = 32;
	localparam int FUNC_W     = 3;
	localparam int POS_W      = 7;
	localparam int STAT_W     = 2;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int GROUP_SIZE = 8;
	localparam int NGROUP     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

	// Command codes.
	typedef enum logic [FUNC_W-1:0] {
		FN_INS_HEAD = 3'd0,
		FN_INS_TAIL = 3'd1,
		FN_INS_POS  = 3'd2,
		FN_REM_HEAD = 3'd3,
		FN_REM_TAIL = 3'd4,
		FN_REM_POS  = 3'd5
	} func_t;

	// Status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [IDX_W-1:0] pos;
	} cmd_t;

	// First-stage result from the controller.
	typedef struct packed {
		logic             valid;
		status_t          status;
		logic [CNT_W-1:0] count;
	} res_t;

endpackage

// ===== rtl/ple_cell.sv =====
// One list slot: holds an entry and shifts toward either neighbor on command.
module ple_cell (
	input  logic                       clk,
	input  logic [ple_pkg::IDX_W-1:0]  idx,
	input  ple_pkg::cmd_t              cmd,
	input  logic [ple_pkg::ITEM_W-1:0] item_in,
	input  logic [ple_pkg::ITEM_W-1:0] left_data,
	input  logic [ple_pkg::ITEM_W-1:0] right_data,
	output logic [ple_pkg::ITEM_W-1:0] data,
	output logic [ple_pkg::ITEM_W-1:0] tap
);
	import ple_pkg::*;

	logic [ITEM_W-1:0] data_q;
	logic              at_pos;
	logic              above_pos;

	// Where this slot sits relative to the affected position.
	assign at_pos    = (idx == cmd.pos);
	assign above_pos = (idx > cmd.pos);

	// Insert opens a gap by shifting up; remove closes it by shifting down.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (at_pos) begin
				data_q <= item_in;
			end else if (above_pos) begin
				data_q <= left_data;
			end
		end else if (cmd.rem && (at_pos || above_pos)) begin
			data_q <= right_data;
		end
	end

	// Offer the entry being removed to the read tree.
	assign tap  = (cmd.rem && at_pos) ? data_q : '0;
	assign data = data_q;

endmodule

// ===== rtl/ple_ctrl.sv =====
// Command decode, bounds checks and item count of the positional list engine.
module ple_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [ple_pkg::FUNC_W-1:0] func,
	input  logic [ple_pkg::POS_W-1:0]  position,
	output ple_pkg::cmd_t              cmd,
	output ple_pkg::res_t              res_s1
);
	import ple_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] tgt;
	logic [CNT_W-1:0] count_nxt;
	logic             is_ins;
	logic             is_rem;
	logic             do_ins;
	logic             do_rem;
	status_t          status;

	// Decode the command into a target slot and check it against the count.
	always_comb begin
		is_ins = (func == FN_INS_HEAD) || (func == FN_INS_TAIL) || (func == FN_INS_POS);
		is_rem = (func == FN_REM_HEAD) || (func == FN_REM_TAIL) || (func == FN_REM_POS);
		case (func)
			FN_INS_HEAD: tgt = '0;
			FN_INS_TAIL: tgt = count_q;
			FN_INS_POS:  tgt = CNT_W'(position);
			FN_REM_HEAD: tgt = '0;
			FN_REM_TAIL: tgt = count_q - CNT_W'(1);
			FN_REM_POS:  tgt = CNT_W'(position);
			default:     tgt = '0;
		endcase
		status = ST_OK;
		if (is_ins) begin
			if (tgt > count_q) begin
				status = ST_BADPOS;
			end else if (count_q >= CNT_W'(CAPACITY)) begin
				status = ST_FULL;
			end
		end else if (is_rem) begin
			if (count_q == '0) begin
				status = ST_EMPTY;
			end else if (tgt >= count_q) begin
				status = ST_BADPOS;
			end
		end
		do_ins = accept && is_ins && (status == ST_OK);
		do_rem = accept && is_rem && (status == ST_OK);
		if (do_ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_nxt = count_q - CNT_W'(1);
		end else begin
			count_nxt = count_q;
		end
	end

	// Broadcast to the cells; a successful target always lies below CAPACITY.
	assign cmd.ins = do_ins;
	assign cmd.rem = do_rem;
	assign cmd.pos = tgt[IDX_W-1:0];

	// Count register and first result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			res_s1  <= '0;
		end else begin
			count_q       <= count_nxt;
			res_s1.valid  <= accept;
			res_s1.status <= status;
			res_s1.count  <= count_nxt;
		end
	end

endmodule

// ===== rtl/positional_list_engine_unit.sv =====
// A result strobes on done once the start transfer has passed the first result stage and the output stage.
// Throughput: one command per cycle; busy never rises, every slot shifts at once.
// The removed entry is read through a two-level registered OR tree over the cells.
// Reset clears the item count, the first result stage and done; entries and output data are not reset.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module positional_list_engine_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [ple_pkg::FUNC_W-1:0] func,
	input  logic [ple_pkg::POS_W-1:0]  position,
	input  logic [ple_pkg::ITEM_W-1:0] item,
	output logic                       done,
	output logic [ple_pkg::ITEM_W-1:0] removed_item,
	output logic [ple_pkg::STAT_W-1:0] status,
	output logic [ple_pkg::CNT_W-1:0]  count
);
	import ple_pkg::*;

	logic              accept;
	cmd_t              cmd;
	res_t              res_s1;
	logic [ITEM_W-1:0] cell_data [CAPACITY];
	logic [ITEM_W-1:0] cell_tap [CAPACITY];
	logic [ITEM_W-1:0] grp_or [NGROUP];
	logic [ITEM_W-1:0] tap_s1 [NGROUP];
	logic [ITEM_W-1:0] tap_all;
	logic              done_s2;
	logic [ITEM_W-1:0] removed_s2;
	status_t           status_s2;
	logic [CNT_W-1:0]  count_s2;

	// Commands are never held off: every slot shifts at once, so busy stays low.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.func     (func),
		.position (position),
		.cmd      (cmd),
		.res_s1   (res_s1)
	);

	// The chain of slots; each takes its neighbors' entries on a shift.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ITEM_W-1:0] left_d;
		logic [ITEM_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		ple_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(i)),
			.cmd        (cmd),
			.item_in    (item),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.tap        (cell_tap[i])
		);
	end

	// First level of the read tree: OR each group of slot taps.
	always_comb begin
		for (int g = 0; g < NGROUP; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				if (g * GROUP_SIZE + k < CAPACITY) begin
					grp_or[g] = grp_or[g] | cell_tap[g * GROUP_SIZE + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGROUP; g++) begin
			tap_s1[g] <= grp_or[g];
		end
	end

	// Second level: OR the group results.
	always_comb begin
		tap_all = '0;
		for (int g = 0; g < NGROUP; g++) begin
			tap_all = tap_all | tap_s1[g];
		end
	end

	// Output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= res_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		removed_s2 <= tap_all;
		status_s2  <= res_s1.status;
		count_s2   <= res_s1.count;
	end

	assign done         = done_s2;
	assign removed_item = removed_s2;
	assign status       = status_s2;
	assign count        = count_s2;

endmodule

// ===== rtl/ple_checker.sv =====
// Port-level checker of the positional list engine and its bind to the top level.
`include "positional_list_engine_unit_defines.svh"

module ple_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic [ple_pkg::ITEM_W-1:0] removed_item,
	input logic [ple_pkg::STAT_W-1:0] status,
	input logic [ple_pkg::CNT_W-1:0]  count
);
	import ple_pkg::*;

	logic xfer;

	assign xfer = start && !busy;

	// Each transfer yields exactly one result on done, and done never rises without a transfer.
	`PLE_ASSERT_NEXT(a_result_follows, clk, arst_n, xfer, ##1 done)
	`PLE_ASSERT_IMPLY(a_no_spurious, clk, arst_n, done, $past(xfer, 2))
	// A failed command returns no item.
	`PLE_ASSERT_IMPLY(a_fail_zero, clk, arst_n, done && (status != ST_OK), removed_item == '0)
	// Empty and full reports agree with the reported count.
	`PLE_ASSERT_IMPLY(a_empty_cnt, clk, arst_n, done && (status == ST_EMPTY), count == '0)
	`PLE_ASSERT_IMPLY(a_full_cnt, clk, arst_n, done && (status == ST_FULL),
		count == CNT_W'(CAPACITY))

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.removed_item (removed_item),
	.status       (status),
	.count        (count)
);

// ===== test/positional_list_engine_unit_tb.sv =====
// Self-checking testbench for the positional list engine: commands, shadow list and result checks.
`timescale 1ns / 100ps

module positional_list_engine_unit_tb;
	import ple_pkg::*;

	// The two command codes that the package leaves unnamed do nothing.
	localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int TAIL_CYCLES     = 6;
	localparam int RANDOM_CHUNKS   = 14;
	localparam int CHUNK_ITEMS     = 100;
	localparam int MAX_PRINTED     = 100;

	// One result of a list command.
	typedef struct {
		logic [ITEM_W-1:0] removed;
		status_t           status;
		logic [CNT_W-1:0]  count;
	} list_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [FUNC_W-1:0] func = '0;
	logic [POS_W-1:0]  position = '0;
	logic [ITEM_W-1:0] item = '0;
	logic              done;
	logic [ITEM_W-1:0] removed_item;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0]  count;

	// Shadow copy of the list contents, head first.
	logic [ITEM_W-1:0] shadow_list[$];
	// Results owed by the block, oldest first.
	list_result_t      owed_results[$];

	int  error_count = 0;
	int  cycle_count = 0;
	bit  sender_gaps_on = 1'b1;

	positional_list_engine_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.position    (position),
		.item        (item),
		.done        (done),
		.removed_item(removed_item),
		.status      (status),
		.count       (count)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic report_mismatch(input string what, input logic [ITEM_W-1:0] got,
			input logic [ITEM_W-1:0] want);
		if (error_count < MAX_PRINTED)
			$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	// Shadow insert; position is checked before fullness.
	function automatic status_t list_insert(input int unsigned at, input logic [ITEM_W-1:0] v);
		if (at > shadow_list.size())
			return ST_BADPOS;
		if (shadow_list.size() >= CAPACITY)
			return ST_FULL;
		shadow_list.insert(at, v);
		return ST_OK;
	endfunction

	// Shadow remove; an empty list wins over a bad position.
	function automatic status_t list_remove(input int unsigned at,
			output logic [ITEM_W-1:0] taken);
		taken = '0;
		if (shadow_list.size() == 0)
			return ST_EMPTY;
		if (at >= shadow_list.size())
			return ST_BADPOS;
		taken = shadow_list[at];
		shadow_list.delete(at);
		return ST_OK;
	endfunction

	// Applies one command to the shadow list and returns the result it owes.
	function automatic list_result_t predict_list_cmd(input logic [FUNC_W-1:0] f,
			input logic [POS_W-1:0] p, input logic [ITEM_W-1:0] v);
		list_result_t r;
		r.removed = '0;
		r.status  = ST_OK;
		case (f)
			FN_INS_HEAD: r.status = list_insert(0, v);
			FN_INS_TAIL: r.status = list_insert(shadow_list.size(), v);
			FN_INS_POS:  r.status = list_insert(32'(p), v);
			FN_REM_HEAD: r.status = list_remove(0, r.removed);
			FN_REM_TAIL: begin
				if (shadow_list.size() == 0)
					r.status = ST_EMPTY;
				else
					r.status = list_remove(shadow_list.size() - 1, r.removed);
			end
			FN_REM_POS:  r.status = list_remove(32'(p), r.removed);
			default:     r.status = ST_OK;
		endcase
		r.count = CNT_W'(shadow_list.size());
		return r;
	endfunction

	// Drives one command after a random gap and records its result at the transfer.
	// Called and returns at a rising edge; start stays high for a back-to-back command.
	task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
			input logic [ITEM_W-1:0] v);
		int gap;
		gap = sender_gaps_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		func     <= f;
		position <= p;
		item     <= v;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		owed_results.push_back(predict_list_cmd(f, p, v));
	endtask

	// Holds the sender off until every owed result has arrived.
	task automatic wait_all_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (owed_results.size() != 0);
	endtask

	// Compares each strobed result with the oldest owed result.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			if (owed_results.size() == 0) begin
				report_mismatch("unexpected result", removed_item, '0);
			end else begin
				want = owed_results.pop_front();
				if (removed_item !== want.removed)
					report_mismatch("removed_item", removed_item, want.removed);
				if (status !== want.status)
					report_mismatch("status", ITEM_W'(status), ITEM_W'(want.status));
				if (count !== want.count)
					report_mismatch("count", ITEM_W'(count), ITEM_W'(want.count));
			end
		end
	end

	// Commands on an empty list, including the unused codes.
	task automatic test_empty_list();
		send_cmd(FN_REM_HEAD, 7'd0, 32'h1234_5678);
		send_cmd(FN_REM_TAIL, 7'd0, '0);
		send_cmd(FN_REM_POS, 7'd0, '0);
		send_cmd(FN_REM_POS, 7'd127, 32'hFFFF_FFFF);
		send_cmd(FN_INS_POS, 7'd1, 32'hDEAD_BEEF);
		send_cmd(FN_INS_POS, 7'd127, 32'hFFFF_FFFF);
		send_cmd(FN_SPARE_6, 7'd127, 32'hFFFF_FFFF);
		send_cmd(FN_SPARE_7, 7'd0, '0);
		send_cmd(FN_INS_POS, 7'd0, 32'hFFFF_FFFF);
	endtask

	// Every command on a short list, with positions at and past the count.
	task automatic test_basic_ops();
		send_cmd(FN_INS_HEAD, 7'd99, 32'h0000_0000);
		send_cmd(FN_INS_TAIL, 7'd0, 32'hA5A5_A5A5);
		send_cmd(FN_INS_POS, 7'd1, 32'h5A5A_5A5A);
		send_cmd(FN_INS_POS, 7'd4, 32'h0000_0001);
		send_cmd(FN_INS_POS, 7'd6, 32'h8000_0000);
		send_cmd(FN_REM_POS, 7'd5, '0);
		send_cmd(FN_REM_POS, 7'd2, 32'hFFFF_FFFF);
		send_cmd(FN_REM_HEAD, 7'd64, 32'hFFFF_FFFF);
		send_cmd(FN_SPARE_7, 7'd64, 32'h7FFF_FFFF);
		send_cmd(FN_REM_TAIL, 7'd127, '0);
		send_cmd(FN_REM_POS, 7'd0, '0);
		send_cmd(FN_REM_TAIL, 7'd0, '0);
		send_cmd(FN_REM_TAIL, 7'd0, '0);
	endtask

	// Fills the list, probes the full cases, then empties it again.
	task automatic test_full_list();
		while (shadow_list.size() < CAPACITY)
			send_cmd(FN_INS_TAIL, POS_W'($urandom_range(0, 127)), $urandom);
		send_cmd(FN_INS_HEAD, 7'd0, 32'hFFFF_FFFF);
		send_cmd(FN_INS_TAIL, 7'd0, 32'h1);
		send_cmd(FN_INS_POS, 7'd64, 32'h2);
		send_cmd(FN_INS_POS, 7'd65, 32'h3);
		send_cmd(FN_REM_POS, 7'd64, '0);
		send_cmd(FN_REM_POS, 7'd63, '0);
		send_cmd(FN_INS_POS, 7'd32, 32'hCAFE_F00D);
		while (shadow_list.size() > 0)
			send_cmd(FUNC_W'(FN_REM_HEAD + $urandom_range(0, 2)),
				POS_W'($urandom_range(0, 127)), $urandom);
	endtask

	// Picks one well-formed or noisy command according to the insert bias.
	task automatic send_random_cmd(input int insert_pct);
		int unsigned roll;
		int unsigned n;
		logic [FUNC_W-1:0] f;
		logic [POS_W-1:0] p;
		logic [ITEM_W-1:0] v;
		roll = $urandom_range(0, 99);
		n = shadow_list.size();
		if (roll < 4)
			f = $urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7;
		else if ($urandom_range(0, 99) < insert_pct)
			f = FUNC_W'(FN_INS_HEAD + $urandom_range(0, 2));
		else
			f = FUNC_W'(FN_REM_HEAD + $urandom_range(0, 2));
		// Most positions land inside the list; the rest cover the whole field.
		if ($urandom_range(0, 99) < 15)
			p = POS_W'($urandom_range(0, 127));
		else if (f == FN_INS_POS)
			p = POS_W'($urandom_range(0, n));
		else
			p = (n == 0) ? 7'd0 : POS_W'($urandom_range(0, n - 1));
		case ($urandom_range(0, 9))
			0:       v = '0;
			1:       v = '1;
			default: v = $urandom;
		endcase
		send_cmd(f, p, v);
	endtask

	// Random traffic in chunks that swing the count between empty and full.
	task automatic test_random_traffic();
		int bias;
		for (int c = 0; c < RANDOM_CHUNKS; c++) begin
			case ($urandom_range(0, 3))
				0:       bias = 85;
				1:       bias = 15;
				2:       bias = 50;
				default: bias = 65;
			endcase
			sender_gaps_on = ($urandom_range(0, 2) != 0);
			for (int i = 0; i < CHUNK_ITEMS; i++)
				send_random_cmd(bias);
			if (c == RANDOM_CHUNKS / 2)
				wait_all_results();
		end
	endtask

	// Test sequence.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		sender_gaps_on = 1'b0;
		test_basic_ops();
		sender_gaps_on = 1'b1;
		test_full_list();
		wait_all_results();
		test_random_traffic();
		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine_unit.sv
rtl/ple_checker.sv
test/positional_list_engine_unit_tb.sv
